>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sth_pkg.sv
`default_nettype none

package sth_pkg;

    localparam int MaxBins   = 256;
    localparam int CountBits = 32;
    localparam int IdxBits   = $clog2(MaxBins);
    localparam int UsedBits  = $clog2(MaxBins + 1);
    localparam int TimeBits  = 64;
    localparam int WidthBits = 32;

    localparam logic CmdAdd   = 1'b0;
    localparam logic CmdRange = 1'b1;

    localparam logic [WidthBits-1:0] BinWidthReset = 32'd1000;

    typedef struct packed {
        logic                command;
        logic [TimeBits-1:0] time_start;
        logic [TimeBits-1:0] time_end;
    } t_request;

    typedef struct packed {
        logic [TimeBits-1:0] range_count;
        logic [TimeBits-1:0] events_total;
        logic                table_full;
    } t_result;

    // Quotient request to the shared divider and its reply.
    typedef struct packed {
        logic                 go;
        logic [TimeBits-1:0]  dividend;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [TimeBits-1:0]  quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> design/sth_divider.sv
`default_nettype none

// Restoring divider: one quotient bit a cycle.
module sth_divider
    import sth_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_div_req             i_req,
    input  wire logic [WidthBits-1:0] i_divisor,
    output t_div_rsp                  o_rsp
);

    localparam int CntBits = $clog2(TimeBits);

    logic                 r_busy;
    logic [CntBits-1:0]   r_cnt;
    logic [TimeBits-1:0]  r_quo;
    logic [WidthBits:0]   r_rem;
    logic [WidthBits-1:0] r_div;
    logic                 r_done;

    logic [WidthBits:0]   w_trial;
    logic [WidthBits:0]   w_shift;
    logic                 w_ge;

    assign w_shift = {r_rem[WidthBits-1:0], r_quo[TimeBits-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_trial = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                // zero width acts as one
                r_div  <= (i_divisor == '0) ? WidthBits'(1) : i_divisor;
            end else if (r_busy) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[TimeBits-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntBits'(TimeBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

>>> design/sparse_time_histogram.sv
`default_nettype none

// Sparse time histogram.
// Channels: a request (command, time_start, time_end) is taken on a rising
// edge with i_start high and o_busy low. Add (command 0) bins the timestamp
// by the configured bin width and increments or inserts that bin (table_full
// if none is free); range (command 1) sums bin(time_start)..bin(time_end - 1).
// One result per request appears on o_result for a single cycle, marked by
// o_valid; the receiver cannot stall, so it must take it then.
// Each bin number comes from a shared restoring divider.
// The table lives in one memory pair (keys, counts), walked one entry at a
// time with registered reads. Add: a division, a linear search, then the
// insertion shift back to front. Range: two divisions, then a walk over
// the bins. One request is in work at a time.
// Bin width is written through i_cfg_we / i_cfg_data; the user must write it
// only while idle, as the block itself does not enforce it.
// Reset: bin width 1000, table empty, total zero; no clearing pass, since
// only entries below the fill count are ever read.
module sparse_time_histogram
    import sth_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire t_request             i_request,
    output logic                      o_busy,
    output logic                      o_valid,
    output t_result                   o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [WidthBits-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_A, S_DIV_B, S_SEEK, S_SEEK_W, S_SHIFT, S_SHIFT_W,
        S_PUT, S_SUM, S_SUM_W, S_DONE
    } t_state;

    localparam logic [CountBits-1:0] CountMax = '1;

    // table memories
    logic [TimeBits-1:0]  r_keys   [MaxBins];
    logic [CountBits-1:0] r_counts [MaxBins];

    t_state               r_state;
    logic [WidthBits-1:0] r_bin_width;
    t_request             r_req;
    logic [UsedBits-1:0]  r_used;
    logic [TimeBits-1:0]  r_total;
    logic [TimeBits-1:0]  r_key_lo;
    logic [TimeBits-1:0]  r_key_hi;
    logic [UsedBits-1:0]  r_pos;
    logic [TimeBits-1:0]  r_rd_key;
    logic [CountBits-1:0] r_rd_cnt;
    logic [TimeBits-1:0]  r_sum;
    logic                 r_full;
    logic                 r_insert;
    logic                 r_valid;
    t_div_req             r_div_req;
    t_div_rsp             w_div_rsp;

    // memory port
    logic                 w_we;
    logic [IdxBits-1:0]   w_waddr;
    logic [TimeBits-1:0]  w_wkey;
    logic [CountBits-1:0] w_wcnt;
    logic [IdxBits-1:0]   w_raddr;

    logic [TimeBits:0]    w_sum_ext;

    sth_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_div_req),
        .i_divisor (r_bin_width),
        .o_rsp     (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_keys[w_waddr]   <= w_wkey;
            r_counts[w_waddr] <= w_wcnt;
        end
        r_rd_key <= r_keys[w_raddr];
        r_rd_cnt <= r_counts[w_raddr];
    end

    assign w_sum_ext = {1'b0, r_sum} + {{(TimeBits + 1 - CountBits){1'b0}}, r_rd_cnt};

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[IdxBits-1:0];
        w_wkey  = r_rd_key;
        w_wcnt  = r_rd_cnt;
        w_raddr = r_pos[IdxBits-1:0];
        unique case (r_state)
            S_SHIFT: begin
                // read the entry below the hole
                w_raddr = IdxBits'(r_pos - 1'b1);
            end
            S_SHIFT_W: begin
                // move it up one place
                w_we    = 1'b1;
                w_waddr = r_pos[IdxBits-1:0];
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[IdxBits-1:0];
                if (!r_insert) begin
                    w_wkey = r_key_lo;
                    w_wcnt = (r_rd_cnt == CountMax) ? r_rd_cnt : r_rd_cnt + 1'b1;
                end else begin
                    w_wkey = r_key_lo;
                    w_wcnt = CountBits'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_width <= BinWidthReset;
            r_used      <= '0;
            r_total     <= '0;
            r_valid     <= 1'b0;
            r_div_req   <= '0;
        end else begin
            r_valid      <= 1'b0;
            r_div_req.go <= 1'b0;
            if (i_cfg_we) begin
                r_bin_width <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req    <= i_request;
                        r_sum    <= '0;
                        r_full   <= 1'b0;
                        r_insert <= 1'b0;
                        r_pos    <= '0;
                        if (i_request.command == CmdAdd) begin
                            if (r_total != '1) begin
                                r_total <= r_total + 1'b1;
                            end
                            r_div_req <= '{go: 1'b1, dividend: i_request.time_start};
                            r_state   <= S_DIV_A;
                        end else if (r_used != '0
                                     && i_request.time_start < i_request.time_end) begin
                            r_div_req <= '{go: 1'b1, dividend: i_request.time_start};
                            r_state   <= S_DIV_A;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV_A: begin
                    if (w_div_rsp.done) begin
                        r_key_lo <= w_div_rsp.quotient;
                        if (r_req.command == CmdAdd) begin
                            r_state <= S_SEEK;
                        end else begin
                            r_div_req <= '{go: 1'b1, dividend: r_req.time_end - 1'b1};
                            r_state   <= S_DIV_B;
                        end
                    end
                end
                S_DIV_B: begin
                    if (w_div_rsp.done) begin
                        r_key_hi <= w_div_rsp.quotient;
                        r_state  <= S_SEEK;
                    end
                end
                S_SEEK: begin
                    // read r_pos issued this cycle
                    if (r_pos >= r_used) begin
                        if (r_req.command == CmdAdd) begin
                            if (r_used == UsedBits'(MaxBins)) begin
                                r_full  <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_pos   <= r_used;
                                r_key_hi <= {{(TimeBits - UsedBits){1'b0}}, r_pos};
                                r_state <= S_SHIFT;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_SEEK_W;
                    end
                end
                S_SEEK_W: begin
                    if (r_rd_key < r_key_lo) begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_SEEK;
                    end else if (r_req.command == CmdRange) begin
                        r_state <= S_SUM_W;
                    end else if (r_rd_key == r_key_lo) begin
                        r_state <= S_PUT;
                    end else if (r_used == UsedBits'(MaxBins)) begin
                        r_full  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        // remember insert point, shift from the end
                        r_key_hi <= {{(TimeBits - UsedBits){1'b0}}, r_pos};
                        r_pos    <= r_used;
                        r_state  <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_pos == r_key_hi[UsedBits-1:0]) begin
                        // hole reached: write the new bin with a count of one
                        r_used   <= r_used + 1'b1;
                        r_insert <= 1'b1;
                        r_state  <= S_PUT;
                    end else begin
                        r_state <= S_SHIFT_W;
                    end
                end
                S_SHIFT_W: begin
                    r_pos   <= r_pos - 1'b1;
                    r_state <= S_SHIFT;
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_SUM: begin
                    if (r_pos >= r_used) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SUM_W;
                    end
                end
                S_SUM_W: begin
                    if (r_rd_key > r_key_hi) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sum   <= w_sum_ext[TimeBits] ? '1 : w_sum_ext[TimeBits-1:0];
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_SUM;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy                = (r_state != S_IDLE);
    assign o_valid               = r_valid;
    assign o_result.range_count  = r_sum;
    assign o_result.events_total = r_total;
    assign o_result.table_full   = r_full;

endmodule

`default_nettype wire

>>> design/sth_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sth_checker
    import sth_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_start,
    input wire logic     o_busy,
    input wire logic     o_valid,
    input wire t_result  o_result
);

    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid && !o_busy, "active after reset")
    `ASSERT_CLK(a_take_busy, i_clk, i_rst_n, i_start && !o_busy |=> o_busy, "request not taken")
    `ASSERT_CLK(a_one_shot, i_clk, i_rst_n, o_valid |=> !o_valid, "result held two cycles")
    `ASSERT_CLK(a_full_add, i_clk, i_rst_n, o_valid && o_result.table_full |-> o_result.range_count == '0, "full flag on range")
    `ASSERT_CLK(a_total_mono, i_clk, i_rst_n, o_valid && $past(o_result.events_total) != '1 |-> o_result.events_total >= $past(o_result.events_total), "total went back")

endmodule

bind sparse_time_histogram sth_checker u_sth_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
